@@ hdl/sm4_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm4_pkg
// Shared types, constants and helper functions for the SM4 block cipher core.
// ----------------------------------------------------------------------------
package sm4_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;

  // Round count and round index width
  localparam int unsigned ROUNDS  = 32;
  localparam int unsigned RND_W   = 5;

  // Family key FK0..FK3, FK0 in the top word
  localparam logic [127:0] FAMILY_KEY = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

  typedef struct packed {
    logic        kind;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } sm4_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } sm4_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_LOAD,
    ST_EXPAND,
    ST_LOAD,
    ST_CRYPT
  } sm4_state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  // Apply the S-box to each byte of a word
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Rotate a word left by a fixed amount
  function automatic logic [31:0] rotl(input logic [31:0] w, input int unsigned n);
    return (w << n) | (w >> (32 - n));
  endfunction

  // CK word for a round: byte j is (4r + j) * 7 mod 256, byte 0 on top
  function automatic logic [31:0] ck_word(input logic [RND_W-1:0] r);
    logic [31:0] w;
    logic [7:0]  idx;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      idx = {1'b0, r, 2'b00} + 8'(j);
      w   = {w[23:0], 8'(idx * 8'd7)};
    end
    return w;
  endfunction

endpackage

@@ hdl/sm4_rk_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm4_rk_mem
// Round key store: 32 words, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sm4_rk_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [sm4_pkg::RND_W-1:0] waddr,
  input  logic [31:0]               wdata,
  input  logic [sm4_pkg::RND_W-1:0] raddr,
  output logic [31:0]               rdata
);
  import sm4_pkg::*;

  logic [31:0] mem [ROUNDS];

  // Write one round key
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/sm4_round.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm4_round
// Shared round function for both key schedule and data rounds:
// next word = w0 ^ L(tau(w1 ^ w2 ^ w3 ^ mix)).
// ----------------------------------------------------------------------------
module sm4_round (
  input  logic [127:0] work,
  input  logic [31:0]  mix,
  input  logic         sched,
  output logic [31:0]  next_word
);
  import sm4_pkg::*;

  logic [31:0] t_in;
  logic [31:0] s;
  logic [31:0] l_data;
  logic [31:0] l_key;

  // Fold the three lower words with the round key or constant
  assign t_in = work[95:64] ^ work[63:32] ^ work[31:0] ^ mix;
  assign s    = sub_word(t_in);

  // Linear maps: data rounds and key schedule
  assign l_data = s ^ rotl(s, 2) ^ rotl(s, 10) ^ rotl(s, 18) ^ rotl(s, 24);
  assign l_key  = s ^ rotl(s, 13) ^ rotl(s, 23);

  assign next_word = work[127:96] ^ (sched ? l_key : l_data);

endmodule

@@ hdl/sm4_block_cipher_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sm4_block_cipher_top
// SM4 128-bit block cipher, ECB, one round per cycle on a shared round unit.
// ----------------------------------------------------------------------------
// A block is taken when start is high and busy is low. With round keys in
// place, a load state takes the block and prefetches the first round key,
// then 32 rounds run through the shared round unit (each round reads one
// key from the round key store), and done is then high for exactly one
// cycle with the result. The receiver cannot stall; capture result whenever
// done is high. A write to key_high or key_low starts a key expansion (load
// plus 32 schedule rounds on the same unit); cfg_ready stays low and busy
// stays high meanwhile. The first block after reset, before any key write,
// first expands the all-zero key, so it takes longer by that expansion. A
// new block may be started in the cycle done is high.
// ----------------------------------------------------------------------------
module sm4_block_cipher_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  sm4_pkg::sm4_in_t              item,
  output logic                          done,
  output sm4_pkg::sm4_out_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);
  import sm4_pkg::*;

  sm4_state_t       state;
  sm4_state_t       state_next;
  logic [63:0]      key_high;
  logic [63:0]      key_low;
  logic             keys_ready;
  logic             pend;
  sm4_in_t          blk;
  logic [127:0]     work;
  logic [RND_W-1:0] rnd;
  logic             last;
  logic             start_acc;
  logic             cfg_acc;
  logic             key_write;
  logic             sched;
  logic             rk_we;
  logic [RND_W-1:0] rd_rnd;
  logic [RND_W-1:0] rd_addr;
  logic [31:0]      rk;
  logic [31:0]      mix;
  logic [31:0]      next_word;

  assign last      = &rnd;
  assign start_acc = start && !busy;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign key_write = cfg_index inside {REG_KEY_HIGH, REG_KEY_LOW};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = keys_ready ? ST_LOAD : ST_KEY_LOAD;
        end else if (cfg_valid && key_write) begin
          state_next = ST_KEY_LOAD;
        end
      end
      ST_KEY_LOAD: state_next = ST_EXPAND;
      ST_EXPAND: begin
        if (last) begin
          state_next = pend ? ST_LOAD : ST_IDLE;
        end
      end
      ST_LOAD:  state_next = ST_CRYPT;
      ST_CRYPT: begin
        if (last) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Decoded controls
  always_comb begin
    busy      = 1'b1;
    cfg_ready = 1'b0;
    sched     = 1'b0;
    rk_we     = 1'b0;
    case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        cfg_ready = !start;
      end
      ST_EXPAND: begin
        sched = 1'b1;
        rk_we = 1'b1;
      end
      default: begin
        sched = 1'b0;
      end
    endcase
  end

  // Round key fetch: one round ahead, reversed order for decrypt
  assign rd_rnd  = (state == ST_LOAD) ? '0 : rnd + RND_W'(1);
  assign rd_addr = blk.kind ? ~rd_rnd : rd_rnd;
  assign mix     = sched ? ck_word(rnd) : rk;

  sm4_round u_round (
    .work      (work),
    .mix       (mix),
    .sched     (sched),
    .next_word (next_word)
  );

  sm4_rk_mem u_rk_mem (
    .clk   (clk),
    .we    (rk_we),
    .waddr (rnd),
    .wdata (next_word),
    .raddr (rd_addr),
    .rdata (rk)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      key_high   <= '0;
      key_low    <= '0;
      keys_ready <= 1'b0;
      pend       <= 1'b0;
      done       <= 1'b0;
      rnd        <= '0;
    end else begin
      state <= state_next;
      done  <= (state == ST_CRYPT) && last;
      if (state == ST_IDLE) begin
        pend <= start;
      end
      // Take a key register transfer
      if (cfg_acc && cfg_index == REG_KEY_HIGH) begin
        key_high <= cfg_data;
      end
      if (cfg_acc && cfg_index == REG_KEY_LOW) begin
        key_low <= cfg_data;
      end
      if (state == ST_EXPAND && last) begin
        keys_ready <= 1'b1;
      end
      // Advance the round counter, restart on each load
      if (state == ST_EXPAND || state == ST_CRYPT) begin
        rnd <= rnd + RND_W'(1);
      end else begin
        rnd <= '0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start_acc) begin
      blk <= item;
    end
    case (state)
      ST_KEY_LOAD: work <= {key_high, key_low} ^ FAMILY_KEY;
      ST_LOAD:     work <= {blk.block_high, blk.block_low};
      ST_EXPAND,
      ST_CRYPT:    work <= {work[95:0], next_word};
      default:     work <= work;
    endcase
    // Capture the word-reversed final state
    if (state == ST_CRYPT && last) begin
      result.result_high <= {next_word, work[31:0]};
      result.result_low  <= {work[63:32], work[95:64]};
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for sm4_block_cipher_top. An in-bench SM4 model
// (key schedule, round function, encrypt and decrypt) predicts each block
// at its start transfer. A monitor compares every done strobe against the
// oldest prediction. Directed tests cover the default key after reset,
// known vectors, field extremes, partial key updates and unused register
// indexes. A random phase follows with key changes, round trips and bursty
// start traffic.
// ----------------------------------------------------------------------------
module tb;
  import sm4_pkg::*;

  // Block direction codes
  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  // Family key words
  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  localparam logic [7:0] SBOX_TBL [256] = '{
    8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
    8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
    8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
    8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
    8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
    8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
    8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
    8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
    8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
    8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
    8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
    8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
    8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
    8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
    8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
    8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
    8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
    8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
    8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
    8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
    8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
    8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
    8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
    8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
    8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
    8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
    8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
    8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
    8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
    8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  sm4_in_t              item = '0;
  logic                 done;
  sm4_out_t             result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  // Model state: key registers, round key schedule and its valid flag
  logic [63:0] key_hi_m = '0;
  logic [63:0] key_lo_m = '0;
  logic [31:0] rk_m [32];
  bit          rk_valid = 1'b0;

  sm4_out_t    predicted_blocks [$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  sm4_out_t    last_out;
  logic        last_kind;
  bit          have_last = 1'b0;

  sm4_block_cipher_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // SM4 model
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] v);
    return {SBOX_TBL[v[31:24]], SBOX_TBL[v[23:16]], SBOX_TBL[v[15:8]], SBOX_TBL[v[7:0]]};
  endfunction

  // Data path linear map after substitution
  function automatic logic [31:0] round_mix(input logic [31:0] v);
    logic [31:0] s;
    s = sbox_word(v);
    return s ^ rol32(s, 2) ^ rol32(s, 10) ^ rol32(s, 18) ^ rol32(s, 24);
  endfunction

  // Key schedule linear map after substitution
  function automatic logic [31:0] sched_mix(input logic [31:0] v);
    logic [31:0] s;
    s = sbox_word(v);
    return s ^ rol32(s, 13) ^ rol32(s, 23);
  endfunction

  // CK word: byte j is (4r + j) * 7 mod 256, byte 0 on top
  function automatic logic [31:0] sched_const(input int r);
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 4; j++) w = {w[23:0], 8'(((4 * r + j) * 7) % 256)};
    return w;
  endfunction

  function automatic void expand_schedule();
    logic [31:0] k [4];
    logic [31:0] nk;
    k[0] = key_hi_m[63:32] ^ FK0;
    k[1] = key_hi_m[31:0] ^ FK1;
    k[2] = key_lo_m[63:32] ^ FK2;
    k[3] = key_lo_m[31:0] ^ FK3;
    for (int r = 0; r < ROUNDS; r++) begin
      nk = k[0] ^ sched_mix(k[1] ^ k[2] ^ k[3] ^ sched_const(r));
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = nk;
      rk_m[r] = nk;
    end
    rk_valid = 1'b1;
  endfunction

  // Apply one register write to the model; unused indexes change nothing
  function automatic void apply_key_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [63:0] data);
    case (idx)
      REG_KEY_HIGH: begin
        key_hi_m = data;
        expand_schedule();
        have_last = 1'b0;
      end
      REG_KEY_LOW: begin
        key_lo_m = data;
        expand_schedule();
        have_last = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // Encrypt or decrypt one block; expand the current key if never done
  function automatic sm4_out_t crypt_block(input sm4_in_t blk);
    logic [31:0] x [4];
    logic [31:0] rk;
    logic [31:0] nx;
    sm4_out_t    o;
    if (!rk_valid) expand_schedule();
    x[0] = blk.block_high[63:32];
    x[1] = blk.block_high[31:0];
    x[2] = blk.block_low[63:32];
    x[3] = blk.block_low[31:0];
    for (int r = 0; r < ROUNDS; r++) begin
      rk = (blk.kind == KIND_DEC) ? rk_m[ROUNDS - 1 - r] : rk_m[r];
      nx = x[0] ^ round_mix(x[1] ^ x[2] ^ x[3] ^ rk);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = nx;
    end
    o.result_high = {x[3], x[2]};
    o.result_low  = {x[1], x[0]};
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly random words, with the extremes mixed in
  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  // Drive one block and hold it until the start transfer, then predict it
  task automatic send_block(input logic knd, input logic [63:0] hi, input logic [63:0] lo);
    sm4_in_t  blk;
    sm4_out_t o;
    blk.kind       = knd;
    blk.block_high = hi;
    blk.block_low  = lo;
    @(negedge clk);
    start <= 1'b1;
    item  <= blk;
    do @(posedge clk); while (busy);
    o = crypt_block(blk);
    predicted_blocks.push_back(o);
    last_out  = o;
    last_kind = knd;
    have_last = 1'b1;
  endtask

  task automatic idle_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Insert a random gap at the end of each burst
  task automatic pace();
    if (burst_left == 0) begin
      idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // Drop start and wait for every predicted block to come back
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (predicted_blocks.size() != 0) @(posedge clk);
  endtask

  // Write one register once the core is idle
  task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_key_write(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_error(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  // Check each done strobe against the oldest prediction
  always @(posedge clk) begin : check_results
    sm4_out_t want;
    if (!rst && done === 1'b1) begin
      if (predicted_blocks.size() == 0) begin
        flag_error("unexpected result, high word", '0, result.result_high);
      end else begin
        want = predicted_blocks.pop_front();
        if (result.result_high !== want.result_high) begin
          flag_error("result_high", want.result_high, result.result_high);
        end
        if (result.result_low !== want.result_low) begin
          flag_error("result_low", want.result_low, result.result_low);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Blocks before any key write run under the all-zero key
  task automatic test_default_key();
    send_block(KIND_ENC, '0, '0);
    send_block(KIND_DEC, '1, '1);
    wait_idle();
  endtask

  // Standard key and plaintext, encrypt and decrypt
  task automatic test_known_vector();
    write_key_reg(REG_KEY_HIGH, 64'h0123456789abcdef);
    write_key_reg(REG_KEY_LOW, 64'hfedcba9876543210);
    send_block(KIND_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(KIND_DEC, 64'h681edf34d206965e, 64'h86b3e94f536e4246);
    wait_idle();
  endtask

  // All-ones and all-zero keys and blocks in both directions
  task automatic test_field_extremes();
    write_key_reg(REG_KEY_HIGH, '1);
    write_key_reg(REG_KEY_LOW, '1);
    send_block(KIND_ENC, '0, '0);
    send_block(KIND_ENC, '1, '1);
    send_block(KIND_DEC, '0, '0);
    send_block(KIND_DEC, '1, '1);
    write_key_reg(REG_KEY_HIGH, '0);
    write_key_reg(REG_KEY_LOW, '0);
    send_block(KIND_ENC, '1, '0);
    send_block(KIND_DEC, '0, '1);
    wait_idle();
  endtask

  // Rewrite one half of the key and keep the other
  task automatic test_partial_key_update();
    write_key_reg(REG_KEY_HIGH, rand64());
    send_block(KIND_ENC, rand64(), rand64());
    send_block(KIND_DEC, rand64(), rand64());
    write_key_reg(REG_KEY_LOW, rand64());
    send_block(KIND_ENC, rand64(), rand64());
    send_block(KIND_DEC, rand64(), rand64());
    wait_idle();
  endtask

  // Writes to unused indexes must leave the key schedule alone
  task automatic test_unused_index();
    write_key_reg(REG_UNUSED_2, '1);
    send_block(KIND_ENC, rand64(), rand64());
    write_key_reg(REG_UNUSED_3, rand64());
    send_block(KIND_DEC, rand64(), rand64());
    wait_idle();
  endtask

  // Hold start high so each block starts in the cycle of the previous done
  task automatic test_back_to_back();
    repeat (4) send_block(1'($urandom_range(0, 1)), rand64(), rand64());
    wait_idle();
  endtask

  // Random key phases with bursty traffic and round trips
  task automatic test_random_traffic();
    int          sent;
    int          phase_len;
    logic        knd;
    logic [63:0] hi;
    logic [63:0] lo;
    sent = 0;
    while (sent < 1700) begin
      case ($urandom_range(0, 4))
        0: begin
          write_key_reg(REG_KEY_HIGH, pick_word());
          write_key_reg(REG_KEY_LOW, pick_word());
        end
        1: write_key_reg(REG_KEY_HIGH, pick_word());
        2: write_key_reg(REG_KEY_LOW, pick_word());
        3: write_key_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3, rand64());
        default: ;
      endcase
      phase_len  = $urandom_range(40, 160);
      burst_left = 0;
      repeat (phase_len) begin
        pace();
        // Feed the last output back the other way now and then
        if (have_last && $urandom_range(0, 3) == 0) begin
          knd = ~last_kind;
          hi  = last_out.result_high;
          lo  = last_out.result_low;
        end else begin
          knd = 1'($urandom_range(0, 1));
          hi  = pick_word();
          lo  = pick_word();
        end
        send_block(knd, hi, lo);
      end
      sent += phase_len;
      wait_idle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_default_key();
    test_known_vector();
    test_field_extremes();
    test_partial_key_update();
    test_unused_index();
    test_back_to_back();
    test_random_traffic();
    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
